// File: hdl/i2cms_pkg.sv
`timescale 1ns / 1ps
package i2cms_pkg;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
  localparam logic [7:0] BYTE_MSB        = 8'h80;

  typedef enum logic [2:0] {
    FN_SAMPLE  = 3'd0,
    FN_START   = 3'd1,
    FN_STOP    = 3'd2,
    FN_WRITE   = 3'd3,
    FN_READ    = 3'd4,
    FN_TX_ACK  = 3'd5,
    FN_RX_ACK  = 3'd6
  } func_t;

  typedef enum logic [3:0] {
    K_NONE,
    K_START,
    K_STOP,
    K_WRITE,
    K_READ_CMD,
    K_TX_ACK,
    K_RX_ACK_CMD,
    K_SAMP_MID,
    K_SAMP_LAST,
    K_ACK_LOW,
    K_ACK_STOP
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       bitv;
    logic       scl0;
    logic       sda0;
  } plan_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] rx;
    logic       nack;
    logic       last;
    logic       fin;
  } res_t;

endpackage

// File: hdl/i2cms_ctrl.sv
`timescale 1ns / 1ps
module i2cms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                take,
  input  i2cms_pkg::func_t    func,
  input  logic [7:0]          tx_byte,
  input  logic                ack_level,
  input  logic                sda_in,
  input  logic                line_scl,
  input  logic                line_sda,
  output i2cms_pkg::plan_t    plan
);
  import i2cms_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_READ,
    PH_ACK
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [3:0] bit_count_r, bit_count_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [8:0] miss_r, miss_nxt;
  logic [7:0] ack_timeout_r;
  logic [7:0] shifted;
  logic [3:0] bc_inc;
  logic [8:0] miss_inc;

  assign shifted  = {shift_r[6:0], sda_in};
  assign bc_inc   = bit_count_r + 4'd1;
  assign miss_inc = miss_r + 9'd1;

  always_comb begin
    phase_nxt     = phase_r;
    bit_count_nxt = bit_count_r;
    shift_nxt     = shift_r;
    miss_nxt      = miss_r;
    plan.kind     = K_NONE;
    plan.data     = 8'd0;
    plan.bitv     = ack_level;
    plan.scl0     = line_scl;
    plan.sda0     = line_sda;
    if (func == FN_SAMPLE) begin
      case (phase_r)
        PH_READ: begin
          shift_nxt = shifted;
          if (bc_inc >= 4'd8) begin
            plan.kind     = K_SAMP_LAST;
            plan.data     = shifted;
            phase_nxt     = PH_IDLE;
            bit_count_nxt = 4'd0;
          end else begin
            plan.kind     = K_SAMP_MID;
            bit_count_nxt = bc_inc;
          end
        end
        PH_ACK: begin
          if (!sda_in) begin
            plan.kind = K_ACK_LOW;
            phase_nxt = PH_IDLE;
          end else if (miss_inc > {1'b0, ack_timeout_r}) begin
            plan.kind = K_ACK_STOP;
            phase_nxt = PH_IDLE;
            miss_nxt  = 9'd0;
          end else begin
            miss_nxt = miss_inc;
          end
        end
        default: ;
      endcase
    end else if (phase_r == PH_IDLE) begin
      case (func)
        FN_START: plan.kind = K_START;
        FN_STOP:  plan.kind = K_STOP;
        FN_WRITE: begin
          plan.kind = K_WRITE;
          plan.data = tx_byte;
        end
        FN_READ: begin
          plan.kind     = K_READ_CMD;
          shift_nxt     = 8'd0;
          bit_count_nxt = 4'd0;
          phase_nxt     = PH_READ;
        end
        FN_TX_ACK: plan.kind = K_TX_ACK;
        FN_RX_ACK: begin
          plan.kind = K_RX_ACK_CMD;
          miss_nxt  = 9'd0;
          phase_nxt = PH_ACK;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      bit_count_r   <= 4'd0;
      shift_r       <= 8'd0;
      miss_r        <= 9'd0;
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else begin
      if (cfg_wr_en) begin
        ack_timeout_r <= cfg_wr_data;
      end
      if (take) begin
        phase_r     <= phase_nxt;
        bit_count_r <= bit_count_nxt;
        shift_r     <= shift_nxt;
        miss_r      <= miss_nxt;
      end
    end
  end

endmodule

// File: hdl/i2cms_emit.sv
`timescale 1ns / 1ps
module i2cms_emit (
  input  i2cms_pkg::plan_t plan,
  input  logic [1:0]       step,
  input  logic [2:0]       bitn,
  output i2cms_pkg::res_t  res
);
  import i2cms_pkg::*;

  logic wbit;

  assign wbit = |(plan.data & (BYTE_MSB >> bitn));

  always_comb begin
    res.scl  = 1'b1;
    res.sda  = 1'b1;
    res.rx   = 8'd0;
    res.nack = 1'b0;
    res.last = 1'b0;
    res.fin  = 1'b0;
    case (plan.kind)
      K_START: begin
        case (step)
          2'd0: begin
            res.scl = plan.scl0;
            res.sda = 1'b1;
          end
          2'd1: res.sda = 1'b1;
          2'd2: res.sda = 1'b0;
          default: begin
            res.scl  = 1'b0;
            res.sda  = 1'b0;
            res.last = 1'b1;
            res.fin  = 1'b1;
          end
        endcase
      end
      K_STOP, K_ACK_STOP: begin
        res.nack = (plan.kind == K_ACK_STOP);
        case (step)
          2'd0: begin
            res.scl = plan.scl0;
            res.sda = 1'b0;
          end
          2'd1: res.sda = 1'b0;
          default: begin
            res.sda  = 1'b1;
            res.last = 1'b1;
            res.fin  = 1'b1;
          end
        endcase
      end
      K_WRITE, K_TX_ACK: begin
        res.sda = (plan.kind == K_WRITE) ? wbit : plan.bitv;
        case (step)
          2'd0: res.scl = (bitn == 3'd0) ? plan.scl0 : 1'b0;
          2'd1: res.scl = 1'b1;
          default: begin
            res.scl  = 1'b0;
            res.last = (plan.kind == K_TX_ACK) || (bitn == 3'd7);
            res.fin  = res.last;
          end
        endcase
      end
      K_READ_CMD, K_RX_ACK_CMD: begin
        res.sda = 1'b1;
        if (step == 2'd0) begin
          res.scl = plan.scl0;
        end else begin
          res.scl = 1'b1;
          res.fin = 1'b1;
        end
      end
      K_SAMP_MID: begin
        res.sda = plan.sda0;
        if (step == 2'd0) begin
          res.scl = 1'b0;
        end else begin
          res.scl = 1'b1;
          res.fin = 1'b1;
        end
      end
      K_SAMP_LAST, K_ACK_LOW: begin
        res.scl  = 1'b0;
        res.sda  = plan.sda0;
        res.rx   = (plan.kind == K_SAMP_LAST) ? plan.data : 8'd0;
        res.last = 1'b1;
        res.fin  = 1'b1;
      end
      default: res.fin = 1'b1;
    endcase
  end

endmodule

// File: hdl/i2c_master_bit_sequencer_core.sv
`timescale 1ns / 1ps
// Path: an input beat is captured in the input register, decoded into the plan register, and its
// result beats are registered in the output register.
// Throughput: one input beat per cycle while no command is active; else a new beat waits
// until the last result beat (up to 24 for a byte write) enters the single result register.
// Reset is synchronous and active low; it releases both lines and returns to idle.
module i2c_master_bit_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // tx_byte[7:0], ack_level[8], sda_in[9], zero fill
  input  logic [2:0]  in_tuser,   // func[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // scl_level[0], sda_level[1], received_byte[9:2], no_ack[10]
  output logic        out_tlast
);
  import i2cms_pkg::*;

  logic        ir_valid_r;
  func_t       ir_func_r;
  logic [7:0]  ir_tx_r;
  logic        ir_ackl_r;
  logic        ir_sda_r;
  logic        active_r;
  logic [1:0]  step_r;
  logic [2:0]  bitn_r;
  plan_t       plan_r;
  plan_t       plan_new;
  res_t        res;
  logic        scl_r;
  logic        sda_r;
  logic        line_scl;
  logic        line_sda;
  logic        emit_fire;
  logic        can_plan;
  logic        ir_take;
  logic        out_valid_r;
  logic [10:0] out_data_r;
  logic        out_last_r;

  assign emit_fire = active_r && (!out_valid_r || out_tready);
  assign can_plan  = !active_r || (emit_fire && res.fin);
  assign ir_take   = ir_valid_r && can_plan;
  assign in_tready = !ir_valid_r || can_plan;
  assign line_scl  = emit_fire ? res.scl : scl_r;
  assign line_sda  = emit_fire ? res.sda : sda_r;

  i2cms_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (ir_take),
    .func        (ir_func_r),
    .tx_byte     (ir_tx_r),
    .ack_level   (ir_ackl_r),
    .sda_in      (ir_sda_r),
    .line_scl    (line_scl),
    .line_sda    (line_sda),
    .plan        (plan_new)
  );

  i2cms_emit u_emit (
    .plan (plan_r),
    .step (step_r),
    .bitn (bitn_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ir_func_r <= func_t'(in_tuser);
      ir_tx_r   <= in_tdata[7:0];
      ir_ackl_r <= in_tdata[8];
      ir_sda_r  <= in_tdata[9];
    end
    if (ir_take) begin
      plan_r <= plan_new;
    end
    if (emit_fire) begin
      out_data_r <= {res.nack, res.rx, res.sda, res.scl};
      out_last_r <= res.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r  <= 1'b0;
      active_r    <= 1'b0;
      step_r      <= 2'd0;
      bitn_r      <= 3'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        ir_valid_r <= 1'b1;
      end else if (ir_take) begin
        ir_valid_r <= 1'b0;
      end
      if (emit_fire) begin
        scl_r <= res.scl;
        sda_r <= res.sda;
      end
      if (ir_take) begin
        active_r <= (plan_new.kind != K_NONE);
        step_r   <= 2'd0;
        bitn_r   <= 3'd0;
      end else if (emit_fire) begin
        if (res.fin) begin
          active_r <= 1'b0;
        end else if (plan_r.kind == K_WRITE && step_r == 2'd2) begin
          step_r <= 2'd0;
          bitn_r <= bitn_r + 3'd1;
        end else begin
          step_r <= step_r + 2'd1;
        end
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_data_r};
  assign out_tlast  = out_last_r;

endmodule

// File: hdl/i2cms_checker.sv
`timescale 1ns / 1ps
module i2cms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Result beat shown straight after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("Stalled result beat changed.");

  a_rx_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[9:2] == 8'd0)
    else $error("Received byte shown on a beat that does not end a command.");

  a_nack_ends_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && out_tdata[10] |-> out_tdata[0] && out_tdata[1])
    else $error("Timed-out acknowledge did not end with both lines released.");

  a_nack_stop_rises: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata[10] && !out_tlast |-> !out_tdata[1])
    else $error("Stop after a timed-out acknowledge released SDA too early.");

endmodule

bind i2c_master_bit_sequencer_core i2cms_checker u_i2cms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
